/* rtl/core/sscs_pkg.sv */
// Shared constants and types for the save sector check and slot select block.
package sscs_pkg;

  // Image layout
  localparam int unsigned SECTORS_PER_SLOT = 14;
  localparam int unsigned SLOT_COUNT       = 2;
  localparam int unsigned WORDS_PER_SECTOR = 1024;

  localparam int unsigned WordIdxW = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned SecW     = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int unsigned SlotW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Word positions inside a sector
  localparam logic [WordIdxW-1:0] DataWords  = WordIdxW'(992);
  localparam logic [WordIdxW-1:0] IdChkWord  = WordIdxW'(1021);
  localparam logic [WordIdxW-1:0] SigWord    = WordIdxW'(1022);
  localparam logic [WordIdxW-1:0] CntWord    = WordIdxW'(1023);

  localparam logic [31:0] SigReset = 32'h0801_2025;

  // Per-sector summary handed from front to back
  typedef struct packed {
    logic              first;      // first sector of an image
    logic              slot_end;   // last sector of its slot
    logic              done;       // last sector of the image
    logic [SlotW-1:0]  slot;
    logic              sig_ok;
    logic [15:0]       chk;        // folded computed checksum
    logic [15:0]       stored;     // stored checksum from the footer
    logic [15:0]       id;
    logic [31:0]       cnt;        // save counter word
  } rec_t;

  // One result word
  typedef struct packed {
    logic        sector_valid;
    logic [15:0] sector_id;
    logic [15:0] computed_checksum;
    logic        image_done;
    logic        image_ok;
    logic        best_slot;
    logic [31:0] best_counter;
  } res_t;

endpackage

/* rtl/core/sscs_front.sv */
// Front end: counts words, sums sector data, captures the footer per sector.
module sscs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                start_req_i,
  input  logic [31:0]         word_i,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  output logic                rec_push_o,
  output sscs_pkg::rec_t      rec_o
);

  logic [sscs_pkg::WordIdxW-1:0] wi_q, wi_d, eff_wi;
  logic [31:0]                   sum_q, sum_d, eff_sum;
  logic [31:0]                   foot_q, foot_d, eff_foot;
  logic                          sig_q, sig_d, eff_sig;
  logic [sscs_pkg::SecW-1:0]     sec_q, sec_d, eff_sec;
  logic [sscs_pkg::SlotW-1:0]    slot_q, slot_d, eff_slot;
  logic                          fin_q, fin_d;
  logic [31:0]                   sig_val_q;
  logic                          proc;
  logic                          slot_end, done;

  // Signature register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_val_q <= sscs_pkg::SigReset;
    end else if (cfg_valid_i) begin
      sig_val_q <= cfg_data_i;
    end
  end

  // A start word sees cleared tracking
  always_comb begin
    eff_wi   = start_req_i ? '0 : wi_q;
    eff_sum  = start_req_i ? '0 : sum_q;
    eff_foot = start_req_i ? '0 : foot_q;
    eff_sig  = start_req_i ? 1'b0 : sig_q;
    eff_sec  = start_req_i ? '0 : sec_q;
    eff_slot = start_req_i ? '0 : slot_q;
  end

  assign proc     = accept_i && (start_req_i || !fin_q);
  assign slot_end = (eff_sec == sscs_pkg::SecW'(sscs_pkg::SECTORS_PER_SLOT - 1));
  assign done     = slot_end && (eff_slot == sscs_pkg::SlotW'(sscs_pkg::SLOT_COUNT - 1));

  // Word processing
  always_comb begin
    wi_d       = wi_q;
    sum_d      = sum_q;
    foot_d     = foot_q;
    sig_d      = sig_q;
    sec_d      = sec_q;
    slot_d     = slot_q;
    fin_d      = fin_q;
    rec_push_o = 1'b0;
    if (proc) begin
      wi_d   = eff_wi + 1'b1;
      sum_d  = (eff_wi < sscs_pkg::DataWords) ? eff_sum + word_i : eff_sum;
      foot_d = (eff_wi == sscs_pkg::IdChkWord) ? word_i : eff_foot;
      sig_d  = (eff_wi == sscs_pkg::SigWord) ? (word_i == sig_val_q) : eff_sig;
      sec_d  = eff_sec;
      slot_d = eff_slot;
      fin_d  = 1'b0;
      if (eff_wi == sscs_pkg::CntWord) begin
        rec_push_o = 1'b1;
        sum_d      = '0;
        foot_d     = '0;
        sig_d      = 1'b0;
        if (done) begin
          fin_d = 1'b1;
        end else if (slot_end) begin
          sec_d  = '0;
          slot_d = eff_slot + 1'b1;
        end else begin
          sec_d = eff_sec + 1'b1;
        end
      end
    end
  end

  // Sector summary
  always_comb begin
    rec_o.first    = (eff_sec == '0) && (eff_slot == '0);
    rec_o.slot_end = slot_end;
    rec_o.done     = done;
    rec_o.slot     = eff_slot;
    rec_o.sig_ok   = eff_sig;
    rec_o.chk      = eff_sum[31:16] + eff_sum[15:0];
    rec_o.stored   = eff_foot[31:16];
    rec_o.id       = eff_foot[15:0];
    rec_o.cnt      = word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      sum_q  <= '0;
      foot_q <= '0;
      sig_q  <= 1'b0;
      sec_q  <= '0;
      slot_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      wi_q   <= wi_d;
      sum_q  <= sum_d;
      foot_q <= foot_d;
      sig_q  <= sig_d;
      sec_q  <= sec_d;
      slot_q <= slot_d;
      fin_q  <= fin_d;
    end
  end

endmodule

/* rtl/core/sscs_rec_fifo.sv */
// Two-entry queue of sector summaries between front and back.
module sscs_rec_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sscs_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output sscs_pkg::rec_t rec_o,
  output logic           empty_o
);

  sscs_pkg::rec_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/core/sscs_back.sv */
// Back end: sector checks, slot completeness, slot choice and result queue.
module sscs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_empty_i,
  input  sscs_pkg::rec_t rec_i,
  output logic           rec_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sscs_pkg::res_t res_o
);

  logic [sscs_pkg::SECTORS_PER_SLOT-1:0] ids_q, ids_d, old_ids, ids_n;
  logic [31:0]                           cnt_q, cnt_d, old_cnt, cnt_n;
  logic                                  tk_q, tk_d, old_tk;
  logic                                  hb_q, hb_d, old_hb;
  logic [sscs_pkg::SlotW-1:0]            cs_q, cs_d, old_cs;
  logic [31:0]                           cc_q, cc_d, old_cc;
  logic                                  valid, take, upd;
  sscs_pkg::res_t                        res_n;

  sscs_pkg::res_t out_q [2];
  logic           owr_q, ord_q;
  logic [1:0]     ocnt_q;
  logic           opop;

  assign rec_pop_o = !rec_empty_i && (ocnt_q != 2'd2);

  // First sector of an image starts from cleared tracking
  always_comb begin
    old_ids = rec_i.first ? '0 : ids_q;
    old_cnt = rec_i.first ? '0 : cnt_q;
    old_tk  = rec_i.first ? 1'b0 : tk_q;
    old_hb  = rec_i.first ? 1'b0 : hb_q;
    old_cs  = rec_i.first ? '0 : cs_q;
    old_cc  = rec_i.first ? '0 : cc_q;
  end

  // Sector check and slot bookkeeping
  always_comb begin
    valid = rec_i.sig_ok && (rec_i.stored == rec_i.chk) &&
            (rec_i.id < 16'(sscs_pkg::SECTORS_PER_SLOT));
    for (int i = 0; i < sscs_pkg::SECTORS_PER_SLOT; i++) begin
      ids_n[i] = old_ids[i] || (valid && (rec_i.id == 16'(i)));
    end
    take  = valid && (rec_i.id == 16'(sscs_pkg::SECTORS_PER_SLOT - 1)) && !old_tk;
    cnt_n = take ? rec_i.cnt : old_cnt;
    upd   = rec_i.slot_end && (&ids_n) && (!old_hb || (cnt_n >= old_cc));
    hb_d  = old_hb || upd;
    cs_d  = upd ? rec_i.slot : old_cs;
    cc_d  = upd ? cnt_n : old_cc;
    ids_d = rec_i.slot_end ? '0 : ids_n;
    cnt_d = rec_i.slot_end ? '0 : cnt_n;
    tk_d  = rec_i.slot_end ? 1'b0 : (old_tk || take);
  end

  // Result word
  always_comb begin
    res_n.sector_valid      = valid;
    res_n.sector_id         = rec_i.id;
    res_n.computed_checksum = rec_i.chk;
    res_n.image_done        = rec_i.done;
    res_n.image_ok          = rec_i.done && hb_d;
    res_n.best_slot         = rec_i.done && hb_d && cs_d[0];
    res_n.best_counter      = (rec_i.done && hb_d) ? cc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q <= '0;
      cnt_q <= '0;
      tk_q  <= 1'b0;
      hb_q  <= 1'b0;
      cs_q  <= '0;
      cc_q  <= '0;
    end else if (rec_pop_o) begin
      ids_q <= ids_d;
      cnt_q <= cnt_d;
      tk_q  <= tk_d;
      hb_q  <= hb_d;
      cs_q  <= cs_d;
      cc_q  <= cc_d;
    end
  end

  // Result queue
  assign empty_o = (ocnt_q == 2'd0);
  assign opop    = pop_i && !empty_o;
  assign res_o   = out_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      out_q[owr_q] <= res_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (rec_pop_o) owr_q <= ~owr_q;
      if (opop)      ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + {1'b0, rec_pop_o} - {1'b0, opop};
    end
  end

endmodule

/* rtl/core/save_sector_check_slot_select.sv */
// Save image sector checker and slot selector, top level.
//
// Input queue side: push_i with start_req_i and word_i; a word is taken at
// a clock edge with push_i high and full_o low. start_req_i marks word 0 of
// a new image and clears all tracking. Each sector is 1024 words; one result
// word comes per sector, on its last word. After the final sector of the last
// slot, words are dropped until the next start.
// Result queue side: while empty_o is low the oldest result is on the output
// ports; pop_i takes it. Once the sector's last word is taken, its summary is
// registered in the summary queue and then its result in the result queue.
// Throughput: one word per cycle while full_o is low, set by the single
// 32-bit add of the data sum in the front end. Two sector summaries queue
// between front and back and two results queue at the output; full_o is high
// while the summary queue holds two, which it reaches only once the result queue is full.
// Configuration: cfg_valid_i writes cfg_data_i to the signature register;
// cfg_ready_o is always high. Write it only while the block is idle.
// Reset: the signature returns to its default, queues empty, and the block
// counts from word 0 of an image even without a start.
module save_sector_check_slot_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        start_req_i,
  input  logic [31:0] word_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic        sector_valid_o,
  output logic [15:0] sector_id_o,
  output logic [15:0] computed_checksum_o,
  output logic        image_done_o,
  output logic        image_ok_o,
  output logic        best_slot_o,
  output logic [31:0] best_counter_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  sscs_pkg::rec_t front_rec, back_rec;
  sscs_pkg::res_t res;
  logic           rec_push, rec_full, rec_pop, rec_empty;
  logic           accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = rec_full;
  assign accept      = push_i && !rec_full;

  sscs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_req_i (start_req_i),
    .word_i      (word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rec_push_o  (rec_push),
    .rec_o       (front_rec)
  );

  sscs_rec_fifo u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (front_rec),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rec_o   (back_rec),
    .empty_o (rec_empty)
  );

  sscs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (back_rec),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .res_o       (res)
  );

  // Result fields
  assign sector_valid_o      = res.sector_valid;
  assign sector_id_o         = res.sector_id;
  assign computed_checksum_o = res.computed_checksum;
  assign image_done_o        = res.image_done;
  assign image_ok_o          = res.image_ok;
  assign best_slot_o         = res.best_slot;
  assign best_counter_o      = res.best_counter;

endmodule

/* rtl/core/sscs_checker.sv */
// Port-level checks for the save sector check and slot select block.
module sscs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic        sector_valid_o,
  input logic [15:0] sector_id_o,
  input logic [15:0] computed_checksum_o,
  input logic        image_done_o,
  input logic        image_ok_o,
  input logic        best_slot_o,
  input logic [31:0] best_counter_o
);

  // Image verdict only rides on the final sector
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && image_ok_o |-> image_done_o)
    else $error("image_ok without image_done");

  // No chosen slot means zeroed slot fields
  a_no_best_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !image_ok_o |-> (best_counter_o == 32'd0) && !best_slot_o)
    else $error("slot fields set without a complete slot");

  // A valid sector carries an id inside the slot
  a_valid_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && sector_valid_o |-> (sector_id_o < 16'(sscs_pkg::SECTORS_PER_SLOT)))
    else $error("valid sector with out of range id");

  // A waiting result word holds until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(sector_id_o) &&
      $stable(computed_checksum_o) && $stable(best_counter_o))
    else $error("waiting result changed");

endmodule

bind save_sector_check_slot_select sscs_checker u_sscs_checker (.*);
